/* design/linear_blend_vertex_skinning_macros.svh */
// assertion macros for the port-level checks in lbvs_chk
// no dependencies
`ifndef LINEAR_BLEND_VERTEX_SKINNING_MACROS_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_MACROS_SVH

// antecedent holds, consequent must hold in the next cycle
`define LBVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbvs check failed");

// antecedent holds, consequent must hold in the same cycle
`define LBVS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbvs check failed");

`endif

/* design/lbvs_pkg.sv */
// types, constants and helper functions for the vertex skinning block
// no dependencies
package lbvs_pkg;

    localparam int LBVS_MAX_BONES = 256;
    localparam int LBVS_FRAC_BITS = 16;
    localparam int ELEMS_PER_BONE = 12;
    localparam int ACC_W          = 48;
    localparam int DIV_STEPS      = ACC_W / 8;
    localparam int NUM_LANES      = 3;

    localparam logic [7:0] NO_BONE = 8'hFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_INFL = 1'b1;

    localparam logic [1:0] COL_X = 2'd0;
    localparam logic [1:0] COL_Y = 2'd1;
    localparam logic [1:0] COL_Z = 2'd2;
    localparam logic [1:0] COL_T = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       vld;
        logic [1:0] row;
        logic [1:0] col;
    } t_tag;

    typedef struct packed {
        logic [7:0] q;
        logic [7:0] r;
    } t_dstep;

    // one base-256 digit of a division by 255
    function automatic t_dstep div255_step(logic [7:0] rem, logic [7:0] byte_in);
        logic [8:0] s;
        logic       ge;
        t_dstep     d;
        s   = {1'b0, rem} + {1'b0, byte_in};
        ge  = (s >= 9'd255);
        d.q = rem + {7'd0, ge};
        d.r = ge ? 8'(s - 9'd255) : s[7:0];
        return d;
    endfunction

    // apply sign to quotient magnitude and saturate to 32 bits
    function automatic logic [31:0] sign_sat32(logic [ACC_W-1:0] mag, logic neg);
        logic signed [ACC_W:0] v;
        logic [ACC_W-31:0]     hi;
        v  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        hi = v[ACC_W:31];
        if ((&hi) || !(|hi)) begin
            return v[31:0];
        end
        return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

endpackage

/* design/lbvs_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lbvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/linear_blend_vertex_skinning.sv */
// top level of the linear blend vertex skinning block
// depends on lbvs_pkg and lbvs_ram
//
// channel | direction | handshake         | payload
// --------+-----------+-------------------+------------------------------------------
// in      | input     | i_valid / o_stall | operation, bone, element, positions, weight
// out     | output    | o_valid / i_stall | out_x, out_y, out_z
// cfg     | input     | i_cfg_we          | i_cfg_data = bone_count
//
// a load beat, and a skipped influence that is not last, leave the block in S_IDLE
// an active influence streams the 12 matrix elements out of the bone ram, one read a
// cycle through a single 32x32 multiplier, then drains the pipe in S_DRAIN
// a last influence adds the divide-by-255 in S_DIV (one byte per cycle) and the load of
// the output register in S_EMIT; the next beat is taken while the result waits on i_stall
// reset is synchronous; the bone ram has no reset and needs no clearing pass
module linear_blend_vertex_skinning
    import lbvs_pkg::*;
#(
    parameter int MAX_BONES = LBVS_MAX_BONES,
    parameter int FRAC_BITS = LBVS_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_bone_index,
    input  logic [3:0]  i_element_index,
    input  logic [31:0] i_element_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [7:0]  i_influence_weight,
    input  logic        i_last_influence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data
);

    localparam int DEPTH  = MAX_BONES * ELEMS_PER_BONE;
    localparam int AW     = $clog2(DEPTH);
    localparam int TERM_W = 64 - FRAC_BITS;
    localparam int ROW_W  = TERM_W + 2;
    localparam int WP_W   = 41;
    localparam int DCW    = $clog2(DIV_STEPS);

    t_state r_state;
    t_state n_state;

    logic [8:0]        r_bone_count;
    logic              in_acc;
    logic              infl_active;
    logic              start_div;
    logic              load_out;
    logic              pipe_empty;

    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic signed [31:0] r_pos_z;
    logic [7:0]         r_weight;
    logic               r_last;
    logic [AW-1:0]      r_base;
    logic [3:0]         r_elem;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [31:0]       ram_rdata;

    t_tag                     r_s1;
    t_tag                     r_s2;
    t_tag                     r_s3;
    t_tag                     r_s4;
    logic signed [31:0]       rd_s;
    logic signed [31:0]       mul_b;
    logic signed [63:0]       product;
    logic signed [63:0]       shifted;
    logic signed [TERM_W-1:0] term;
    logic signed [TERM_W-1:0] r_term;
    logic signed [ROW_W-1:0]  r_row;
    logic signed [ROW_W-1:0]  row_full;
    logic [ROW_W-32:0]        row_hi;
    logic signed [31:0]       row_sat;
    logic signed [31:0]       r_rowsat;
    logic signed [WP_W-1:0]   r_wprod;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;

    logic signed [ACC_W-1:0]  r_acc  [NUM_LANES];
    logic [ACC_W-1:0]         r_dvd  [NUM_LANES];
    logic [ACC_W-1:0]         r_quo  [NUM_LANES];
    logic [7:0]               r_rem  [NUM_LANES];
    logic                     r_neg  [NUM_LANES];
    t_dstep                   dstep  [NUM_LANES];
    logic [DCW-1:0]           r_dcnt;

    logic              r_ovalid;
    logic [31:0]       r_out_x;
    logic [31:0]       r_out_y;
    logic [31:0]       r_out_z;

    assign in_acc = i_valid && !o_stall;
    assign infl_active = (i_bone_index != NO_BONE)
                      && ({1'b0, i_bone_index} < r_bone_count)
                      && ({1'b0, i_bone_index} < 9'(MAX_BONES))
                      && (i_influence_weight != 8'd0);
    assign pipe_empty = !(r_s1.vld || r_s2.vld || r_s3.vld || r_s4.vld);

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_stall   = 1'b1;
        start_div = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (in_acc && i_operation == OP_INFL) begin
                    if (infl_active) begin
                        n_state = S_RUN;
                    end else if (i_last_influence) begin
                        n_state   = S_DIV;
                        start_div = 1'b1;
                    end
                end
            end
            S_RUN: begin
                if (r_elem == 4'(ELEMS_PER_BONE - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (pipe_empty) begin
                    if (r_last) begin
                        n_state   = S_DIV;
                        start_div = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (r_dcnt == DCW'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    n_state  = S_IDLE;
                    load_out = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // config and item capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bone_count <= 9'd0;
        end else if (i_cfg_we) begin
            r_bone_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_INFL) begin
            r_pos_x  <= i_pos_x;
            r_pos_y  <= i_pos_y;
            r_pos_z  <= i_pos_z;
            r_weight <= i_influence_weight;
            r_last   <= i_last_influence;
            r_base   <= AW'(32'(i_bone_index) * 32'(ELEMS_PER_BONE));
        end
    end

    // bone store
    assign ram_we    = in_acc && (i_operation == OP_LOAD)
                    && (i_element_index < 4'(ELEMS_PER_BONE))
                    && ({1'b0, i_bone_index} < 9'(MAX_BONES));
    assign ram_waddr = AW'(32'(i_bone_index) * 32'(ELEMS_PER_BONE) + 32'(i_element_index));
    assign ram_re    = (r_state == S_RUN);
    assign ram_raddr = r_base + AW'(r_elem);

    lbvs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_element_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // element issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem <= 4'd0;
            r_s1   <= '0;
        end else begin
            if (r_state == S_RUN) begin
                r_s1   <= t_tag'{vld: 1'b1, row: r_elem[3:2], col: r_elem[1:0]};
                r_elem <= (r_elem == 4'(ELEMS_PER_BONE - 1)) ? 4'd0 : r_elem + 4'd1;
            end else begin
                r_s1 <= '0;
            end
        end
    end

    // multiply stage
    assign rd_s = $signed(ram_rdata);

    always_comb begin
        case (r_s1.col)
            COL_Y:   mul_b = r_pos_y;
            COL_Z:   mul_b = r_pos_z;
            default: mul_b = r_pos_x;
        endcase
    end

    assign product = 64'(rd_s) * 64'(mul_b);
    assign shifted = product >>> FRAC_BITS;
    assign term    = (r_s1.col == COL_T) ? TERM_W'(rd_s) : shifted[TERM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= r_s1;
        end
        r_term <= term;
    end

    // row sum stage
    assign row_full = r_row + ROW_W'(r_term);
    assign row_hi   = row_full[ROW_W-1:31];
    assign row_sat  = ((&row_hi) || !(|row_hi)) ? row_full[31:0]
                    : (row_full[ROW_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= t_tag'{vld: r_s2.vld && (r_s2.col == COL_T), row: r_s2.row,
                           col: r_s2.col};
        end
        if (r_s2.vld) begin
            r_row <= (r_s2.col == COL_X) ? ROW_W'(r_term) : row_full;
        end
        r_rowsat <= row_sat;
    end

    // weight stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4 <= '0;
        end else begin
            r_s4 <= r_s3;
        end
        r_wprod <= WP_W'(r_rowsat) * WP_W'($signed({1'b0, r_weight}));
    end

    // accumulate stage
    assign acc_sum = (ACC_W+1)'(r_acc[r_s4.row]) + (ACC_W+1)'(r_wprod);
    assign acc_sat = (acc_sum[ACC_W] == acc_sum[ACC_W-1]) ? acc_sum[ACC_W-1:0]
                   : {acc_sum[ACC_W], {(ACC_W-1){!acc_sum[ACC_W]}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_acc[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LANES; l++) begin
                if (start_div) begin
                    r_acc[l] <= '0;
                end else if (r_s4.vld && r_s4.row == 2'(l)) begin
                    r_acc[l] <= acc_sat;
                end
            end
        end
    end

    // divide by 255, one byte per cycle, on all three lanes
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            dstep[l] = div255_step(r_rem[l], r_dvd[l][ACC_W-1 -: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (start_div) begin
            r_dcnt <= '0;
        end else if (r_state == S_DIV) begin
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (start_div) begin
                r_neg[l] <= r_acc[l][ACC_W-1];
                r_dvd[l] <= r_acc[l][ACC_W-1] ? ACC_W'(-r_acc[l]) : r_acc[l];
                r_rem[l] <= 8'd0;
                r_quo[l] <= '0;
            end else if (r_state == S_DIV) begin
                r_dvd[l] <= {r_dvd[l][ACC_W-9:0], 8'd0};
                r_rem[l] <= dstep[l].r;
                r_quo[l] <= {r_quo[l][ACC_W-9:0], dstep[l].q};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (load_out) begin
            r_out_x <= sign_sat32(r_quo[0], r_neg[0]);
            r_out_y <= sign_sat32(r_quo[1], r_neg[1]);
            r_out_z <= sign_sat32(r_quo[2], r_neg[2]);
        end
    end

    assign o_valid = r_ovalid;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;
    assign o_out_z = r_out_z;

endmodule

/* design/lbvs_chk.sv */
// port-level checks for the vertex skinning block, bound to the top level
// depends on lbvs_pkg and linear_blend_vertex_skinning_macros.svh
`include "linear_blend_vertex_skinning_macros.svh"

module lbvs_chk
    import lbvs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_operation,
    input logic        i_last_influence,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_x,
    input logic [31:0] o_out_y,
    input logic [31:0] o_out_z
);

    // stalled result beat holds
    `LBVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z))

    // a load beat leaves the block ready for the next beat
    `LBVS_ASSERT_NEXT(a_load_one_cycle, i_clk, i_rst_n, i_valid && !o_stall && i_operation == OP_LOAD, !o_stall)

    // a last influence always starts work before the next beat
    `LBVS_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_valid && !o_stall && i_operation == OP_INFL && i_last_influence, o_stall)

    // a result beat appears only out of a busy cycle
    `LBVS_ASSERT_SAME(a_out_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

endmodule

bind linear_blend_vertex_skinning lbvs_chk u_lbvs_chk (.*);

/* bench/lbvs_skin_checker.sv */
// checker for the vertex skinning block: predicts each blended position and compares
// watches the input, output and bone count ports; depends on lbvs_pkg
module lbvs_skin_checker
    import lbvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_bone_index,
    input  logic [3:0]  i_element_index,
    input  logic [31:0] i_element_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [7:0]  i_influence_weight,
    input  logic        i_last_influence,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_out_x,
    input  logic [31:0] i_out_y,
    input  logic [31:0] i_out_z,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_open_count
);

    localparam longint FULL_WEIGHT = 255;
    localparam longint POS32       = 64'sd2147483647;
    localparam longint NEG32       = -64'sd2147483648;
    localparam longint ACC_HI      = (64'sd1 <<< 47) - 64'sd1;
    localparam longint ACC_LO      = -(64'sd1 <<< 47);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_skin_pos;

    logic signed [31:0] bone_mat [LBVS_MAX_BONES * ELEMS_PER_BONE];
    longint             acc_x;
    longint             acc_y;
    longint             acc_z;
    logic [8:0]         bone_count;
    t_skin_pos          blended_pos_q [$];
    int                 miss_total = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // one row of the bone's affine transform, products floored to the fraction width
    function automatic longint bone_row(int base, longint x, longint y, longint z);
        longint s;
        s = ((longint'(bone_mat[base]) * x) >>> LBVS_FRAC_BITS)
          + ((longint'(bone_mat[base + 1]) * y) >>> LBVS_FRAC_BITS)
          + ((longint'(bone_mat[base + 2]) * z) >>> LBVS_FRAC_BITS)
          + longint'(bone_mat[base + 3]);
        return clamp(s, NEG32, POS32);
    endfunction

    task automatic note_miss(string what);
        miss_total++;
        if (miss_total <= 10) begin
            $display("skin check: %s", what);
        end
    endtask

    always @(posedge i_clk) begin
        longint    px;
        longint    py;
        longint    pz;
        longint    w;
        int        base;
        t_skin_pos want;
        t_skin_pos got;
        if (!i_rst_n) begin
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            bone_count = '0;
            blended_pos_q.delete();
        end else begin
            if (i_cfg_we) begin
                bone_count = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_LOAD) begin
                    if (i_element_index < ELEMS_PER_BONE) begin
                        bone_mat[int'(i_bone_index) * ELEMS_PER_BONE + int'(i_element_index)]
                            = i_element_value;
                    end
                end else begin
                    if (i_bone_index != NO_BONE && 9'(i_bone_index) < bone_count
                            && i_influence_weight != 0) begin
                        base = int'(i_bone_index) * ELEMS_PER_BONE;
                        px = longint'($signed(i_pos_x));
                        py = longint'($signed(i_pos_y));
                        pz = longint'($signed(i_pos_z));
                        w  = longint'(i_influence_weight);
                        acc_x = clamp(acc_x + w * bone_row(base, px, py, pz), ACC_LO, ACC_HI);
                        acc_y = clamp(acc_y + w * bone_row(base + 4, px, py, pz), ACC_LO, ACC_HI);
                        acc_z = clamp(acc_z + w * bone_row(base + 8, px, py, pz), ACC_LO, ACC_HI);
                    end
                    if (i_last_influence) begin
                        want.x = 32'(clamp(acc_x / FULL_WEIGHT, NEG32, POS32));
                        want.y = 32'(clamp(acc_y / FULL_WEIGHT, NEG32, POS32));
                        want.z = 32'(clamp(acc_z / FULL_WEIGHT, NEG32, POS32));
                        blended_pos_q.push_back(want);
                        acc_x = 0;
                        acc_y = 0;
                        acc_z = 0;
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got.x = i_out_x;
                got.y = i_out_y;
                got.z = i_out_z;
                if (blended_pos_q.size() == 0) begin
                    note_miss($sformatf("beat with none expected: %h %h %h",
                        got.x, got.y, got.z));
                end else begin
                    want = blended_pos_q.pop_front();
                    if (want.x !== got.x) begin
                        note_miss($sformatf("out_x expected %h, got %h", want.x, got.x));
                    end
                    if (want.y !== got.y) begin
                        note_miss($sformatf("out_y expected %h, got %h", want.y, got.y));
                    end
                    if (want.z !== got.z) begin
                        note_miss($sformatf("out_z expected %h, got %h", want.z, got.z));
                    end
                end
            end
        end
        o_fail_count <= miss_total;
        o_open_count <= blended_pos_q.size();
    end

endmodule

/* bench/linear_blend_vertex_skinning_tb.sv */
// top of the vertex skinning testbench: clock, reset, bone loads, vertex streams, verdict
// depends on lbvs_pkg, linear_blend_vertex_skinning and lbvs_skin_checker
module linear_blend_vertex_skinning_tb;
    import lbvs_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int RUN_LIMIT     = 12 * 400000;

    typedef struct {
        logic        op;
        logic [7:0]  bone;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [7:0]  weight;
        logic        last;
    } t_skin_beat;

    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        i_valid            = 1'b0;
    logic        o_stall;
    logic        i_operation        = OP_LOAD;
    logic [7:0]  i_bone_index       = '0;
    logic [3:0]  i_element_index    = '0;
    logic [31:0] i_element_value    = '0;
    logic [31:0] i_pos_x            = '0;
    logic [31:0] i_pos_y            = '0;
    logic [31:0] i_pos_z            = '0;
    logic [7:0]  i_influence_weight = '0;
    logic        i_last_influence   = 1'b0;
    logic        o_valid;
    logic        i_stall            = 1'b0;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic        i_cfg_we           = 1'b0;
    logic [8:0]  i_cfg_data         = '0;

    int          fail_count;
    int          open_results;
    bit          calm        = 1'b0;
    int          cur_count   = 0;
    int          beats_sent  = 0;
    logic [11:0] elem_seen [256] = '{default: '0};
    int          ready_bones [$];

    linear_blend_vertex_skinning i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_bone_index       (i_bone_index),
        .i_element_index    (i_element_index),
        .i_element_value    (i_element_value),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_pos_z            (i_pos_z),
        .i_influence_weight (i_influence_weight),
        .i_last_influence   (i_last_influence),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_x            (o_out_x),
        .o_out_y            (o_out_y),
        .o_out_z            (o_out_z),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data)
    );

    lbvs_skin_checker skin_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_operation        (i_operation),
        .i_bone_index       (i_bone_index),
        .i_element_index    (i_element_index),
        .i_element_value    (i_element_value),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_pos_z            (i_pos_z),
        .i_influence_weight (i_influence_weight),
        .i_last_influence   (i_last_influence),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_out_x            (o_out_x),
        .i_out_y            (o_out_y),
        .i_out_z            (o_out_z),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_open_count       (open_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // output side back-pressure
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 8);
    end

    function automatic logic [31:0] pick_element_value();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 32'h7FFF_FFFF;
        end
        if (r < 10) begin
            return 32'h8000_0000;
        end
        if (r < 14) begin
            return '0;
        end
        if (r < 30) begin
            return $urandom();
        end
        return 32'($urandom_range(262143)) - 32'd131072;
    endfunction

    function automatic logic [31:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return 32'h7FFF_FFFF;
        end
        if (r < 10) begin
            return 32'h8000_0000;
        end
        if (r < 30) begin
            return $urandom();
        end
        return 32'($urandom_range(33554431)) - 32'd16777216;
    endfunction

    function automatic logic [7:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return '0;
        end
        if (r < 25) begin
            return 8'hFF;
        end
        return 8'($urandom_range(254, 1));
    endfunction

    function automatic logic [7:0] pick_ready_bone();
        return 8'(ready_bones[$urandom_range(ready_bones.size() - 1)]);
    endfunction

    // true when the influence would read the bone store
    function automatic bit reads_store(logic [7:0] bone, logic [7:0] weight);
        int eff;
        eff = (cur_count > LBVS_MAX_BONES) ? LBVS_MAX_BONES : cur_count;
        return bone != NO_BONE && int'(bone) < eff && weight != 0;
    endfunction

    task automatic push_beat(t_skin_beat b);
        while (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_operation        <= b.op;
        i_bone_index       <= b.bone;
        i_element_index    <= b.elem;
        i_element_value    <= b.value;
        i_pos_x            <= b.px;
        i_pos_y            <= b.py;
        i_pos_z            <= b.pz;
        i_influence_weight <= b.weight;
        i_last_influence   <= b.last;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
    endtask

    task automatic send_load(logic [7:0] bone, logic [3:0] elem, logic [31:0] value,
                             logic last);
        t_skin_beat b;
        b.op     = OP_LOAD;
        b.bone   = bone;
        b.elem   = elem;
        b.value  = value;
        b.px     = $urandom();
        b.py     = $urandom();
        b.pz     = $urandom();
        b.weight = 8'($urandom_range(255));
        b.last   = last;
        if (elem < ELEMS_PER_BONE && elem_seen[bone] != 12'hFFF) begin
            elem_seen[bone][elem] = 1'b1;
            if (elem_seen[bone] == 12'hFFF) begin
                ready_bones.push_back(int'(bone));
            end
        end
        push_beat(b);
    endtask

    task automatic send_influence(logic [7:0] bone, logic [31:0] px, logic [31:0] py,
                                  logic [31:0] pz, logic [7:0] weight, logic last);
        t_skin_beat b;
        b.op     = OP_INFL;
        b.bone   = bone;
        b.elem   = 4'($urandom_range(15));
        b.value  = $urandom();
        b.px     = px;
        b.py     = py;
        b.pz     = pz;
        b.weight = weight;
        b.last   = last;
        push_beat(b);
    endtask

    task automatic load_bone(logic [7:0] bone);
        for (int e = 0; e < ELEMS_PER_BONE; e++) begin
            send_load(bone, 4'(e), pick_element_value(), 1'($urandom_range(1)));
        end
    endtask

    task automatic send_vertex();
        int         n;
        int         r;
        bit         close;
        logic [7:0] bone;
        logic [7:0] weight;
        n     = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
        close = ($urandom_range(99) >= 3);
        for (int i = 0; i < n; i++) begin
            weight = pick_weight();
            r = $urandom_range(99);
            if (r < 70) begin
                bone = pick_ready_bone();
            end else if (r < 80) begin
                bone = NO_BONE;
            end else begin
                bone = 8'($urandom_range(255));
            end
            if (reads_store(bone, weight) && elem_seen[bone] != 12'hFFF) begin
                bone = pick_ready_bone();
            end
            if ($urandom_range(99) < 4) begin
                send_load(8'($urandom_range(255)), 4'($urandom_range(15)),
                          pick_element_value(), 1'($urandom_range(1)));
            end
            send_influence(bone, pick_coord(), pick_coord(), pick_coord(), weight,
                           close && i == n - 1);
        end
    endtask

    // wait until every result is out and the pipe has drained
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (open_results != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bone_count(int count);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 9'(count);
        cur_count  = count;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(int count, int n);
        int r;
        int target;
        write_bone_count(count);
        target = beats_sent + n;
        while (beats_sent < target) begin
            r = $urandom_range(99);
            if (r < 6) begin
                load_bone(8'($urandom_range(255)));
            end else if (r < 12) begin
                send_load(8'($urandom_range(255)), 4'($urandom_range(15)),
                          pick_element_value(), 1'($urandom_range(1)));
            end else begin
                send_vertex();
            end
        end
    endtask

    initial begin
        logic [31:0] seed_mat [12];
        seed_mat = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty vertex, ignored loads, skip rules, saturation
        write_bone_count(0);
        send_influence(8'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 8'hFF, 1'b1);
        for (int e = 0; e < ELEMS_PER_BONE; e++) begin
            send_load(8'd0, 4'(e), seed_mat[e], 1'b0);
        end
        send_load(8'd0, 4'd13, 32'h0, 1'b1);
        send_load(NO_BONE, 4'd15, 32'hFFFF_FFFF, 1'b1);
        write_bone_count(1);
        send_influence(8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 1'b0);
        send_influence(8'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'hFF, 1'b1);
        send_influence(NO_BONE, 32'h0001_0000, 32'h0, 32'h0, 8'hFF, 1'b1);
        send_influence(8'd1, 32'h0001_0000, 32'h0, 32'h0, 8'hFF, 1'b1);
        send_influence(8'd0, 32'h0001_0000, 32'h0, 32'h0, 8'h00, 1'b1);
        send_influence(8'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 8'h01, 1'b1);
        send_influence(8'd0, pick_coord(), pick_coord(), pick_coord(), 8'h80, 1'b0);
        send_influence(NO_BONE, pick_coord(), pick_coord(), pick_coord(), 8'hC8, 1'b1);

        // full bone range, then one long vertex that drives the accumulator to its limits
        write_bone_count(LBVS_MAX_BONES);
        for (int b = 1; b <= 6; b++) begin
            load_bone(8'(b));
        end
        for (int e = 0; e < ELEMS_PER_BONE; e++) begin
            send_load(8'd254, 4'(e),
                      (e < 4) ? 32'h7FFF_FFFF : (e < 8) ? 32'h8000_0000 : pick_element_value(),
                      1'b0);
        end
        for (int i = 0; i < 300; i++) begin
            send_influence(8'd254, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF,
                           i == 299);
        end

        run_phase(LBVS_MAX_BONES, 150);
        calm = 1'b1;
        run_phase(511, 130);
        calm = 1'b0;
        run_phase($urandom_range(255, 2), 130);
        run_phase(1, 100);
        run_phase(0, 40);
        run_phase(LBVS_MAX_BONES, 110);
        settle();

        if (fail_count == 0 && open_results == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
